// ===== src/lzsm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lzsm_pkg
// Shared types and codes for the zone distance store.
// ----------------------------------------------------------------------------
package lzsm_pkg;

	localparam logic       OP_FRAME = 1'b0;
	localparam logic       OP_QUERY = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_COORD = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	localparam logic [15:0] FAR_MM  = 16'hFFFF;

	// zone index wide enough for the largest store of 64 zones
	typedef logic [5:0] zone_t;

	typedef struct packed {
		logic        op;
		logic [7:0]  start_index;
		logic [15:0] first_mm;
		logic [15:0] second_mm;
		logic [15:0] third_mm;
		logic [7:0]  col_x;
		logic [7:0]  row_y;
	} item_t;

	typedef struct packed {
		logic [15:0] nearest_mm;
		logic [15:0] dot_mm;
		logic [1:0]  status;
	} result_t;

	// classified work handed from front to back
	typedef struct packed {
		logic        op;
		logic [1:0]  status;
		logic [2:0]  wen;
		zone_t       zone;
		logic [15:0] mm0;
		logic [15:0] mm1;
		logic [15:0] mm2;
	} job_t;

endpackage
`default_nettype wire

// ===== src/lzsm_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lzsm_front
// Classifies an incoming beat: frame write targets or query zone and status.
// ----------------------------------------------------------------------------
module lzsm_front #(
	parameter int ZONE_COUNT = 64
) (
	input  wire            grid_is_8x8,
	input  lzsm_pkg::item_t item,
	output lzsm_pkg::job_t  job
);
	import lzsm_pkg::*;

	logic [8:0] t0, t1, t2;
	logic [2:0] wen;
	logic       x_out, y_out;
	zone_t      qidx;
	logic       coord_bad;

	always_comb begin
		t0 = {1'b0, item.start_index};
		t1 = t0 + 9'd1;
		t2 = t0 + 9'd2;
		wen[0] = t0 < 9'(ZONE_COUNT);
		wen[1] = t1 < 9'(ZONE_COUNT);
		wen[2] = t2 < 9'(ZONE_COUNT);

		x_out = grid_is_8x8 ? (item.col_x > 8'd7) : (item.col_x > 8'd3);
		y_out = grid_is_8x8 ? (item.row_y > 8'd7) : (item.row_y > 8'd3);
		// mirrored row-major: (side-1-y)*side + (side-1-x)
		qidx = grid_is_8x8 ? {~item.row_y[2:0], ~item.col_x[2:0]}
		                   : {2'b00, ~item.row_y[1:0], ~item.col_x[1:0]};
		coord_bad = x_out || y_out || ({1'b0, qidx} >= 7'(ZONE_COUNT));

		job.op  = item.op;
		job.mm0 = item.first_mm;
		job.mm1 = item.second_mm;
		job.mm2 = item.third_mm;
		if (item.op == OP_FRAME) begin
			job.wen    = wen;
			job.zone   = item.start_index[5:0];
			job.status = (&wen) ? ST_OK : ST_RANGE;
		end else begin
			job.wen    = 3'b000;
			job.zone   = qidx;
			job.status = coord_bad ? ST_COORD : ST_OK;
		end
	end

endmodule
`default_nettype wire

// ===== src/lzsm_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lzsm_queue
// Two-entry queue of classified jobs between front and back.
// ----------------------------------------------------------------------------
module lzsm_queue (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            push,
	input  lzsm_pkg::job_t push_job,
	output logic           full,
	input  wire            pop,
	output logic           head_valid,
	output lzsm_pkg::job_t head_job
);
	import lzsm_pkg::*;

	job_t       slot_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push, do_pop;

	assign full       = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head_job   = slot_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= ~wr_ptr_q;
			if (do_pop) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + 2'(do_push) - 2'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_ptr_q] <= push_job;
	end

endmodule
`default_nettype wire

// ===== src/lzsm_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lzsm_back
// Executes jobs: zone writes, dot read, sequential minimum scan, result reg.
// ----------------------------------------------------------------------------
module lzsm_back #(
	parameter int ZONE_COUNT = 64
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               grid_is_8x8,
	input  wire               job_valid,
	input  lzsm_pkg::job_t    job,
	output logic              pop,
	output logic              idle,
	output logic              result_valid,
	input  wire               result_ready,
	output lzsm_pkg::result_t result
);
	import lzsm_pkg::*;

	localparam int AW    = $clog2(ZONE_COUNT);
	localparam int LAST8 = ZONE_COUNT - 1;
	localparam int LAST4 = 15;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_WRITE = 7'b0000010,
		S_QREAD = 7'b0000100,
		S_QCAP  = 7'b0001000,
		S_SCAN  = 7'b0010000,
		S_DRAIN = 7'b0100000,
		S_OUT   = 7'b1000000
	} state_t;

	state_t          state_q;
	job_t            job_q;
	logic [1:0]      k_q;
	logic [AW-1:0]   scan_idx_q;
	logic [AW-1:0]   scan_last;
	logic            scan_vld_s1;
	logic [15:0]     dot_q;
	logic [15:0]     min_q;
	logic            res_valid_q;
	result_t         res_q;

	logic [15:0]     mem [ZONE_COUNT];
	logic            zvld_q [ZONE_COUNT];
	logic            mem_we;
	logic [AW-1:0]   mem_wa;
	logic [15:0]     mem_wd;
	logic [AW-1:0]   rd_addr;
	logic [15:0]     rd_data_s1;
	logic            rd_vld_s1;
	logic [15:0]     rd_eff;

	assign scan_last    = grid_is_8x8 ? AW'(LAST8) : AW'(LAST4);
	assign pop          = (state_q == S_IDLE) && job_valid;
	assign idle         = (state_q == S_IDLE);
	assign result_valid = res_valid_q;
	assign result       = res_q;
	assign rd_eff       = rd_vld_s1 ? rd_data_s1 : 16'd0;
	assign rd_addr      = (state_q == S_QREAD) ? job_q.zone[AW-1:0] : scan_idx_q;

	always_comb begin
		mem_we = (state_q == S_WRITE) && job_q.wen[k_q];
		mem_wa = job_q.zone[AW-1:0] + AW'(k_q);
		case (k_q)
			2'd0:    mem_wd = job_q.mm0;
			2'd1:    mem_wd = job_q.mm1;
			default: mem_wd = job_q.mm2;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		rd_data_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ZONE_COUNT; i++) zvld_q[i] <= 1'b0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (mem_we) zvld_q[mem_wa] <= 1'b1;
			rd_vld_s1 <= zvld_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			k_q         <= 2'd0;
			scan_idx_q  <= '0;
			scan_vld_s1 <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			scan_vld_s1 <= (state_q == S_SCAN);
			if ((state_q == S_OUT) && (!res_valid_q || result_ready)) begin
				res_valid_q <= 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					k_q        <= 2'd0;
					scan_idx_q <= '0;
					if (job_valid) begin
						if (job.op == OP_FRAME)     state_q <= S_WRITE;
						else if (job.status != ST_OK) state_q <= S_SCAN;
						else                          state_q <= S_QREAD;
					end
				end
				S_WRITE: begin
					k_q <= k_q + 2'd1;
					if (k_q == 2'd2) state_q <= S_SCAN;
				end
				S_QREAD: state_q <= S_QCAP;
				S_QCAP:  state_q <= S_SCAN;
				S_SCAN: begin
					scan_idx_q <= scan_idx_q + AW'(1);
					if (scan_idx_q == scan_last) state_q <= S_DRAIN;
				end
				S_DRAIN: state_q <= S_OUT;
				S_OUT: begin
					if (!res_valid_q || result_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= job;
			dot_q <= 16'd0;
			min_q <= FAR_MM;
		end else begin
			if (state_q == S_QCAP) dot_q <= rd_eff;
			if (scan_vld_s1 && (rd_eff < min_q)) min_q <= rd_eff;
		end
		if ((state_q == S_OUT) && (!res_valid_q || result_ready)) begin
			res_q.nearest_mm <= min_q;
			res_q.dot_mm     <= dot_q;
			res_q.status     <= job_q.status;
		end
	end

	a_err_no_dot: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && (res_q.status != ST_OK)) |-> (res_q.dot_mm == 16'd0))
		else $error("error result carries a dot distance");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (scan_idx_q <= scan_last))
		else $error("scan index past active zones");

	a_out_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT) |-> ($past(state_q) == S_DRAIN || $past(state_q) == S_OUT))
		else $error("result stage entered without finished scan");

	a_scan_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		scan_vld_s1 |-> ($past(state_q) == S_SCAN))
		else $error("scan data flagged outside scan");

endmodule
`default_nettype wire

// ===== src/lidar_zone_store_min_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lidar_zone_store_min_core
// Zone distance store with dot query and nearest-zone report.
// ----------------------------------------------------------------------------
// Active zones: 16 on the 4x4 grid, ZONE_COUNT (64 by default) on the 8x8 grid.
// Jobs run one at a time; each ends with a scan of all active zones, one zone per cycle.
// Two-entry job queue plus result register decouple input and output.
// Grid select write waits until no job is queued or executing.
// Reset clears grid select to 4x4, zone valid bits (all zones read 0), queue.
module lidar_zone_store_min_core #(
	parameter int ZONE_COUNT = 64
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               item_valid,
	output logic              item_ready,
	input  lzsm_pkg::item_t   item,
	output logic              result_valid,
	input  wire               result_ready,
	output lzsm_pkg::result_t result,
	input  wire               cfg_valid,
	output logic              cfg_ready,
	input  wire               cfg_data
);
	import lzsm_pkg::*;

	logic  grid_q;
	job_t  front_job;
	job_t  head_job;
	logic  q_full, head_valid, pop;
	logic  back_idle;

	assign cfg_ready  = back_idle && !head_valid;
	assign item_ready = !q_full && !(cfg_valid && cfg_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			grid_q <= cfg_data;
		end
	end

	lzsm_front #(.ZONE_COUNT(ZONE_COUNT)) u_front (
		.grid_is_8x8 (grid_q),
		.item        (item),
		.job         (front_job)
	);

	lzsm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (item_valid && item_ready),
		.push_job   (front_job),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	lzsm_back #(.ZONE_COUNT(ZONE_COUNT)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.grid_is_8x8  (grid_q),
		.job_valid    (head_valid),
		.job          (head_job),
		.pop          (pop),
		.idle         (back_idle),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule
`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the zone distance store with nearest-zone report.
// Sends measurement frames and dot queries over valid/ready and keeps a shadow
// zone store and grid select. Every result beat is checked field by field, in
// order, against the shadow. Directed edge cases come first, then random
// traffic under both grid sizes and several sender/receiver idling patterns.
// ----------------------------------------------------------------------------
module tb;
	import lzsm_pkg::*;

	localparam int ZONES = 64;

	logic    clk;
	logic    arst_n;
	logic    item_valid;
	logic    item_ready;
	item_t   item;
	logic    result_valid;
	logic    result_ready;
	result_t result;
	logic    cfg_valid;
	logic    cfg_ready;
	logic    cfg_data;

	logic [15:0] zone_mm [ZONES];
	logic        grid_8x8;
	result_t     pending_zone_results [$];
	int          errors = 0;
	int          send_idle_pct;
	int          recv_stall_pct;

	lidar_zone_store_min_core #(
		.ZONE_COUNT(ZONES)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#40_000_000;
		$display("tb: FAIL");
		$finish;
	end

	// updates the shadow store and returns the expected result
	function automatic result_t apply_zone_item(input item_t it);
		result_t     r;
		logic [15:0] mm [3];
		int unsigned idx;
		int unsigned side;
		int unsigned n;
		r.nearest_mm = FAR_MM;
		r.dot_mm     = '0;
		r.status     = ST_OK;
		mm[0] = it.first_mm;
		mm[1] = it.second_mm;
		mm[2] = it.third_mm;
		if (it.op == OP_FRAME) begin
			for (int k = 0; k < 3; k++) begin
				idx = int'(it.start_index) + k;
				if (idx < ZONES) begin
					zone_mm[idx] = mm[k];
				end else begin
					r.status = ST_RANGE;
				end
			end
		end else begin
			side = grid_8x8 ? 8 : 4;
			if (it.col_x >= side || it.row_y >= side) begin
				r.status = ST_COORD;
			end else begin
				idx = (side - 1 - it.row_y) * side + (side - 1 - it.col_x);
				if (idx < ZONES) begin
					r.dot_mm = zone_mm[idx];
				end else begin
					r.status = ST_COORD;
				end
			end
		end
		n = grid_8x8 ? 64 : 16;
		if (n > ZONES) begin
			n = ZONES;
		end
		for (int i = 0; i < n; i++) begin
			if (zone_mm[i] < r.nearest_mm) begin
				r.nearest_mm = zone_mm[i];
			end
		end
		return r;
	endfunction

	function automatic item_t frame_at(input logic [7:0] start, input logic [15:0] a,
			input logic [15:0] b, input logic [15:0] c);
		item_t it;
		it = '0;
		it.op          = OP_FRAME;
		it.start_index = start;
		it.first_mm    = a;
		it.second_mm   = b;
		it.third_mm    = c;
		return it;
	endfunction

	function automatic item_t query_at(input logic [7:0] x, input logic [7:0] y);
		item_t it;
		it = '0;
		it.op    = OP_QUERY;
		it.col_x = x;
		it.row_y = y;
		return it;
	endfunction

	function automatic logic [15:0] rand_mm();
		int unsigned pick;
		pick = $urandom_range(15);
		if (pick == 0) begin
			return 16'h0000;
		end
		if (pick < 3) begin
			return FAR_MM;
		end
		if (pick < 6) begin
			return 16'($urandom_range(16'hFFFF, 16'hF000));
		end
		return 16'($urandom);
	endfunction

	// mostly in-store frames and in-grid queries, the rest anywhere
	function automatic item_t rand_zone_item();
		item_t       it;
		int unsigned side;
		int unsigned pick;
		side           = grid_8x8 ? 8 : 4;
		pick           = $urandom_range(9);
		it.op          = 1'($urandom_range(1));
		it.start_index = 8'($urandom);
		it.first_mm    = rand_mm();
		it.second_mm   = rand_mm();
		it.third_mm    = rand_mm();
		it.col_x       = 8'($urandom);
		it.row_y       = 8'($urandom);
		if (it.op == OP_FRAME) begin
			if (pick < 7) begin
				it.start_index = 8'($urandom_range(side * side - 1));
			end else if (pick < 9) begin
				it.start_index = 8'($urandom_range(66));
			end
		end else if (pick < 8) begin
			it.col_x = 8'($urandom_range(side - 1));
			it.row_y = 8'($urandom_range(side - 1));
		end
		return it;
	endfunction

	task automatic send_zone_item(input item_t it);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item       <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (!item_ready);
		pending_zone_results.push_back(apply_zone_item(it));
	endtask

	task automatic wait_results_done();
		@(negedge clk);
		item_valid <= 1'b0;
		while (pending_zone_results.size() != 0) @(posedge clk);
	endtask

	task automatic write_grid_select(input logic g);
		wait_results_done();
		@(negedge clk);
		cfg_data  <= g;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		grid_8x8 = g;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// cleared store, 4x4 grid
	task automatic test_reset_state();
		send_zone_item(query_at(8'd0, 8'd0));
		send_zone_item(query_at(8'd3, 8'd3));
		send_zone_item(query_at(8'd4, 8'd0));
		send_zone_item(query_at(8'd0, 8'd4));
		send_zone_item(query_at(8'hFF, 8'hFF));
	endtask

	// all active zones far, then one slightly nearer
	task automatic test_far_fill();
		for (int s = 0; s < 18; s += 3) begin
			send_zone_item(frame_at(8'(s), FAR_MM, FAR_MM, FAR_MM));
		end
		send_zone_item(frame_at(8'd5, 16'hFFFE, FAR_MM, FAR_MM));
		send_zone_item(query_at(8'd1, 8'd2));
	endtask

	// frames at the top of the store and beyond it
	task automatic test_frame_edges();
		send_zone_item(frame_at(8'd61, 16'h0000, 16'hAAAA, 16'h5555));
		send_zone_item(frame_at(8'd62, 16'h5555, 16'hAAAA, 16'h0000));
		send_zone_item(frame_at(8'd63, 16'h0001, 16'h0000, 16'h0000));
		send_zone_item(frame_at(8'd64, 16'h0000, 16'h0000, 16'h0000));
		send_zone_item(frame_at(8'hFF, FAR_MM, FAR_MM, FAR_MM));
	endtask

	task automatic test_grid_8x8();
		write_grid_select(1'b1);
		send_zone_item(query_at(8'd7, 8'd7));
		send_zone_item(query_at(8'd0, 8'd0));
		send_zone_item(query_at(8'd8, 8'd0));
		send_zone_item(query_at(8'd0, 8'd8));
		send_zone_item(query_at(8'hFF, 8'h80));
		write_grid_select(1'b0);
	endtask

	task automatic test_random_traffic();
		for (int ph = 0; ph < 8; ph++) begin
			write_grid_select(ph[2] ^ ph[0]);
			case (ph % 4)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 84;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 84;
				end
				default: begin
					send_idle_pct  = 8;
					recv_stall_pct = 8;
				end
			endcase
			for (int n = 0; n < 212; n++) begin
				// hold off until the pipe is empty, then resume
				if (ph == 2 && n == 106) begin
					wait_results_done();
				end
				send_zone_item(rand_zone_item());
			end
		end
	endtask

	initial begin
		result_ready = 1'b0;
		forever begin
			@(negedge clk);
			result_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (result_valid && result_ready) begin
			if (pending_zone_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result beat %h", $time, result);
			end else begin
				want = pending_zone_results.pop_front();
				if (result.nearest_mm !== want.nearest_mm) begin
					errors++;
					$display("%0t: nearest_mm exp %h got %h", $time, want.nearest_mm,
						result.nearest_mm);
				end
				if (result.dot_mm !== want.dot_mm) begin
					errors++;
					$display("%0t: dot_mm exp %h got %h", $time, want.dot_mm, result.dot_mm);
				end
				if (result.status !== want.status) begin
					errors++;
					$display("%0t: status exp %h got %h", $time, want.status, result.status);
				end
			end
		end
	end

	initial begin
		arst_n         = 1'b0;
		item_valid     = 1'b0;
		item           = '0;
		cfg_valid      = 1'b0;
		cfg_data       = 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		grid_8x8       = 1'b0;
		foreach (zone_mm[i]) begin
			zone_mm[i] = '0;
		end
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		test_reset_state();
		test_far_fill();
		test_frame_edges();
		test_grid_8x8();
		test_random_traffic();
		wait_results_done();
		repeat (100) @(posedge clk);
		if (errors == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

endmodule
